>>> hdl/udc_pkg.sv
package udc_pkg;

   // Byte counter saturates here
   localparam logic [16:0] CountMax = 17'h1FFFF;

   // Pseudo-header protocol word and minimum UDP header size
   localparam logic [15:0] UdpProto  = 16'd17;
   localparam logic [16:0] HeaderMin = 17'd8;
   localparam logic [15:0] AllOnes   = 16'hFFFF;

   // Byte positions that close each header field
   localparam logic [16:0] IdxSrcPort   = 17'd1;
   localparam logic [16:0] IdxDstPort   = 17'd3;
   localparam logic [16:0] IdxLength    = 17'd5;
   localparam logic [16:0] IdxChecksum  = 17'd7;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SHORT,
      STATUS_BAD_LENGTH,
      STATUS_MISMATCH
   } status_type;

   // Registered input beat with its pseudo-header sum already folded
   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] pseudo_sum;
   } beat_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] checksum_value;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] datagram_length;
      logic        generated;
   } result_type;

   // End-around carry fold of a sum of a few 16-bit words
   function automatic logic [15:0] ones_fold(input logic [19:0] s);
      logic [16:0] a;
      logic [16:0] b;
      a = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      b = {1'b0, a[15:0]} + {16'd0, a[16]};
      return b[15:0];
   endfunction

endpackage

>>> hdl/udc_in_stage.sv
module udc_in_stage
   import udc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_byte[7:0], source_address[39:8],
                                    // destination_address[71:40]
   input  logic        req_tuser,   // kind
   input  logic        req_tlast,   // last_byte
   output beat_type    beat,
   output logic        beat_valid,
   input  logic        beat_take
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;
   beat_type beat_in;
   logic     accept;
   logic [19:0] pseudo_raw;

   assign req_tready = !reset && (!valid_ff || beat_take);
   assign accept     = req_tvalid && req_tready;

   // Pseudo-header words: addresses and protocol (length is added at the end)
   always_comb begin
      pseudo_raw = 20'(req_tdata[39:24]) + 20'(req_tdata[23:8])
                 + 20'(req_tdata[71:56]) + 20'(req_tdata[55:40])
                 + 20'(UdpProto);
      beat_in.kind       = req_tuser;
      beat_in.data_byte  = req_tdata[7:0];
      beat_in.last_byte  = req_tlast;
      beat_in.pseudo_sum = ones_fold(pseudo_raw);
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (beat_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

   assign beat       = beat_ff;
   assign beat_valid = valid_ff;

endmodule

>>> hdl/udc_sum_core.sv
module udc_sum_core
   import udc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  beat_type   beat,
   input  logic       beat_take,
   output result_type result
);

   logic [16:0] count_ff;
   logic [16:0] count_in;
   logic [15:0] sum_ff;
   logic [7:0]  pend_ff;
   logic [15:0] hlen_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;
   logic [15:0] rxsum_ff;
   logic        mode_ff;

   logic        first;
   logic        odd;
   logic        mode;
   logic [15:0] base;
   logic [7:0]  pend_old;
   logic [7:0]  pend_in;
   logic [15:0] word;
   logic [15:0] hlen_in;
   logic [15:0] sport_in;
   logic [15:0] dport_in;
   logic [15:0] rxsum_in;
   logic [15:0] term;
   logic [15:0] sum_in;
   logic [16:0] count_next;
   logic        pad;
   logic [15:0] pad_term;
   logic [16:0] extra;
   logic [15:0] chk_sum;
   logic [15:0] chk;
   logic        chk_match;
   status_type  status;

   // Per-byte datapath: capture header fields and add at most one word
   always_comb begin
      first    = (count_ff == '0);
      odd      = count_ff[0];
      mode     = first ? beat.kind : mode_ff;
      base     = first ? beat.pseudo_sum : sum_ff;
      pend_old = first ? 8'd0 : pend_ff;
      word     = {pend_old, beat.data_byte};
      pend_in  = odd ? pend_old : beat.data_byte;

      hlen_in  = first ? 16'd0 : hlen_ff;
      sport_in = first ? 16'd0 : sport_ff;
      dport_in = first ? 16'd0 : dport_ff;
      rxsum_in = first ? 16'd0 : rxsum_ff;
      if (odd) begin
         case (count_ff)
            IdxSrcPort:  sport_in = word;
            IdxDstPort:  dport_in = word;
            IdxLength:   hlen_in  = word;
            IdxChecksum: rxsum_in = word;
            default: ;
         endcase
      end

      // Checksum field counts as zero; verify stops at the length that the length field gives
      term = 16'd0;
      if (odd && count_ff != IdxChecksum) begin
         if (mode) begin
            term = (count_ff != IdxLength) ? word : 16'd0;
         end else if (count_ff < IdxChecksum || count_ff < {1'b0, hlen_in}) begin
            term = word;
         end else if (count_ff == {1'b0, hlen_in}) begin
            term = {pend_old, 8'h00};
         end
      end
      sum_in = ones_fold(20'(base) + 20'(term));

      count_next = (count_ff == CountMax) ? count_ff : count_ff + 17'd1;
   end

   // End of datagram: trailing pad byte, length words, final checksum or compare
   always_comb begin
      if (mode) begin
         pad   = count_next[0];
         extra = {count_next[15:0], 1'b0};
      end else begin
         pad   = count_next[0] && ((count_next - 17'd1) < {1'b0, hlen_in});
         extra = {1'b0, hlen_in};
      end
      pad_term  = pad ? {pend_in, 8'h00} : 16'd0;
      chk_sum   = ones_fold(20'(sum_in) + 20'(pad_term) + 20'(extra));
      chk       = ~chk_sum;
      chk_match = (chk == rxsum_in) || (chk == 16'd0 && rxsum_in == AllOnes);

      if (count_next < HeaderMin) begin
         status = STATUS_SHORT;
      end else if ({1'b0, hlen_in} > count_next || {1'b0, hlen_in} < HeaderMin) begin
         status = STATUS_BAD_LENGTH;
      end else if (rxsum_in == 16'd0 || chk_match) begin
         status = STATUS_OK;
      end else begin
         status = STATUS_MISMATCH;
      end

      result.source_port      = sport_in;
      result.destination_port = dport_in;
      result.generated        = mode;
      if (mode) begin
         result.status          = STATUS_OK;
         result.checksum_value  = (chk == 16'd0) ? AllOnes : chk;
         result.datagram_length = count_next[15:0];
      end else begin
         result.status          = status;
         result.checksum_value  = rxsum_in;
         result.datagram_length = hlen_in;
      end
   end

   assign count_in = beat.last_byte ? 17'd0 : count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (beat_take) begin
         count_ff <= count_in;
      end
   end

   // Header and sum state; the first byte of a datagram overrides all of it
   always_ff @(posedge clock) begin
      if (beat_take) begin
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
         hlen_ff  <= hlen_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         rxsum_ff <= rxsum_in;
         mode_ff  <= mode;
      end
   end

endmodule

>>> hdl/udc_out_stage.sv
module udc_out_stage
   import udc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  result_type  result,
   input  logic        result_load,
   output logic        result_space,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status[1:0], checksum_value[17:2],
                                    // source_port[33:18], destination_port[49:34],
                                    // datagram_length[65:50], zero[71:66]
   output logic        rsp_tuser    // generated
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign result_space = !valid_ff || rsp_tready;

   always_comb begin
      if (result_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, data_ff.datagram_length, data_ff.destination_port,
                        data_ff.source_port, data_ff.checksum_value, data_ff.status};
   assign rsp_tuser  = data_ff.generated;

endmodule

>>> hdl/udp_datagram_checksum_engine.sv
// A result beat is valid once its last byte has passed the input and result registers;
// a held result can delay it. One byte per cycle; the running one's complement sum
// closes in an end-around-carry fold per byte. A held result stalls only a byte that ends a
// datagram, and with it the bytes behind it, until the result register is taken.
// Reset (synchronous, active high) empties the input and result registers and clears the
// byte count, so the next accepted byte starts a new datagram.
module udp_datagram_checksum_engine
   import udc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_byte[7:0], source_address[39:8],
                                    // destination_address[71:40]
   input  logic        req_tuser,   // kind
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status[1:0], checksum_value[17:2],
                                    // source_port[33:18], destination_port[49:34],
                                    // datagram_length[65:50], zero[71:66]
   output logic        rsp_tuser    // generated
);

   beat_type   beat;
   logic       beat_valid;
   logic       beat_take;
   result_type result;
   logic       result_space;
   logic       result_load;

   // A byte moves on unless it ends a datagram and the result register is full
   assign beat_take   = beat_valid && (result_space || !beat.last_byte);
   assign result_load = beat_take && beat.last_byte;

   udc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .beat       (beat),
      .beat_valid (beat_valid),
      .beat_take  (beat_take)
   );

   udc_sum_core u_sum_core (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .beat_take (beat_take),
      .result    (result)
   );

   udc_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .result_load  (result_load),
      .result_space (result_space),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

>>> hdl/udc_checker.sv
module udc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // A new result beat follows an accepted last byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result beat without a preceding last byte");

   // Generated results carry status accepted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == 2'd0)
      else $error("generated result with nonzero status");

   // A generated checksum is never sent as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[17:2] != 16'd0)
      else $error("generated checksum of zero");

endmodule

bind udp_datagram_checksum_engine udc_checker u_checker (.*);

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import udc_pkg::*;

   // Cycles with no beat on either side before the run is declared hung
   localparam int QuietLimit = 2000;

   typedef logic [7:0] octet_queue_type[$];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // Results the datagram model says are still owed by the block
   result_type pending_results[$];

   // Datagram model state
   logic [16:0] dg_sum;
   logic [16:0] dg_count = '0;
   logic [15:0] dg_length;
   logic [15:0] dg_src_port;
   logic [15:0] dg_dst_port;
   logic [15:0] dg_rx_csum;
   logic [7:0]  dg_high_byte;
   logic        dg_generate;

   udp_datagram_checksum_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // One's complement add with end-around carry, kept folded
   task automatic add_to_sum(input logic [15:0] w);
      logic [31:0] s;
      s = dg_sum + w;
      s = s[15:0] + s[31:16];
      s = s[15:0] + s[31:16];
      dg_sum = s[16:0];
   endtask

   // Advance the datagram model by one accepted byte
   task automatic model_byte(input logic kind, input logic [7:0] data, input logic last,
                             input logic [31:0] src, input logic [31:0] dst);
      logic [16:0] idx;
      logic [16:0] n;
      logic [15:0] word;
      logic [15:0] len16;
      logic [15:0] csum;
      result_type  r;
      // first byte: latch mode, clear header, seed pseudo-header
      if (dg_count == 0) begin
         dg_generate = kind;
         dg_length = '0;
         dg_src_port = '0;
         dg_dst_port = '0;
         dg_rx_csum = '0;
         dg_high_byte = '0;
         dg_sum = '0;
         add_to_sum(src[31:16]);
         add_to_sum(src[15:0]);
         add_to_sum(dst[31:16]);
         add_to_sum(dst[15:0]);
         add_to_sum(UdpProto);
      end
      idx = dg_count;
      if (!idx[0]) begin
         dg_high_byte = data;
      end else begin
         word = {dg_high_byte, data};
         if (idx == IdxSrcPort) dg_src_port = word;
         else if (idx == IdxDstPort) dg_dst_port = word;
         else if (idx == IdxLength) dg_length = word;
         else if (idx == IdxChecksum) dg_rx_csum = word;
         // checksum field counts as zero; generate skips the length field
         if (idx == IdxChecksum) begin
         end else if (dg_generate) begin
            if (idx != IdxLength) add_to_sum(word);
         end else if (idx < IdxChecksum || idx < {1'b0, dg_length}) begin
            add_to_sum(word);
         end else if (idx == {1'b0, dg_length}) begin
            add_to_sum({dg_high_byte, 8'h00});
         end
      end
      if (dg_count < CountMax) dg_count++;
      if (!last) return;

      n = dg_count;
      r.source_port = dg_src_port;
      r.destination_port = dg_dst_port;
      if (dg_generate) begin
         len16 = n[15:0];
         if (n[0]) add_to_sum({dg_high_byte, 8'h00});
         add_to_sum(len16);
         add_to_sum(len16);
         csum = ~dg_sum[15:0];
         if (csum == 0) csum = AllOnes;
         r.status = STATUS_OK;
         r.checksum_value = csum;
         r.datagram_length = len16;
         r.generated = 1'b1;
      end else begin
         if (n[0] && (n - 17'd1) < {1'b0, dg_length}) add_to_sum({dg_high_byte, 8'h00});
         if (n < HeaderMin) begin
            r.status = STATUS_SHORT;
         end else if ({1'b0, dg_length} > n || {1'b0, dg_length} < HeaderMin) begin
            r.status = STATUS_BAD_LENGTH;
         end else if (dg_rx_csum == 0) begin
            r.status = STATUS_OK;
         end else begin
            add_to_sum(dg_length);
            csum = ~dg_sum[15:0];
            if (csum == dg_rx_csum || (csum == 0 && dg_rx_csum == AllOnes))
               r.status = STATUS_OK;
            else
               r.status = STATUS_MISMATCH;
         end
         r.checksum_value = dg_rx_csum;
         r.datagram_length = dg_length;
         r.generated = 1'b0;
      end
      pending_results.push_back(r);
      dg_count = '0;
      dg_sum = '0;
      dg_high_byte = '0;
   endtask

   // Send one byte beat; called and returns at a falling edge
   task automatic send_beat(input logic kind, input logic [7:0] data, input logic last,
                            input logic [31:0] src, input logic [31:0] dst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dst, src, data};
      req_tuser <= kind;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      model_byte(kind, data, last, src, dst);
      @(negedge clock);
   endtask

   // Mode and addresses only matter on the first byte; the rest carry noise
   task automatic send_datagram(input logic kind, input octet_queue_type q,
                                input logic [31:0] src, input logic [31:0] dst);
      for (int i = 0; i < q.size(); i++) begin
         if (i == 0)
            send_beat(kind, q[i], q.size() == 1, src, dst);
         else
            send_beat(1'($urandom_range(1)), q[i], i == q.size() - 1, $urandom, $urandom);
      end
   endtask

   // Correct wire checksum for a datagram whose length field equals len
   function automatic logic [15:0] udp_checksum(input logic [31:0] src, input logic [31:0] dst,
                                                input octet_queue_type q, input int len);
      logic [31:0] acc;
      logic [15:0] w;
      acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + UdpProto + len[15:0];
      for (int i = 0; i < len; i += 2) begin
         w[15:8] = q[i];
         w[7:0] = (i + 1 < len) ? q[i + 1] : 8'h00;
         if (i != 6) acc += w;
      end
      while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
      w = ~acc[15:0];
      return (w == 0) ? AllOnes : w;
   endfunction

   task automatic test_directed_cases();
      octet_queue_type q;
      // single odd byte generate, all-ones source, zero destination
      q = '{8'hFF};
      send_datagram(1'b1, q, 32'hFFFF_FFFF, 32'h0000_0000);
      // sum works out to all ones, so the sent checksum is 0xFFFF
      q = '{8'hFF, 8'hDE, 8'h00, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hFF};
      send_datagram(1'b0, q, 32'h0000_0000, 32'h0000_0000);
      // two zero-valued bytes generate, all-ones destination
      q = '{8'h00, 8'h00};
      send_datagram(1'b1, q, 32'h0000_0000, 32'hFFFF_FFFF);
      // shorter than a header
      q = '{8'h12, 8'h34, 8'h56};
      send_datagram(1'b0, q, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // length field below the header size
      q = '{8'h00, 8'h35, 8'hFF, 8'hFF, 8'h00, 8'h04, 8'h12, 8'h34};
      send_datagram(1'b0, q, 32'hC0A8_0001, 32'h0A00_0001);
   endtask

   task automatic test_random_traffic(input int byte_budget);
      octet_queue_type q;
      int sent;
      int n;
      int hlen;
      int style;
      logic kind;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] csum;
      sent = 0;
      while (sent < byte_budget) begin
         src = $urandom;
         dst = $urandom;
         style = $urandom_range(99);
         q.delete();
         if (style < 25) begin
            kind = 1'b1;
            n = $urandom_range(1, 40);
         end else if (style < 33) begin
            kind = 1'b0;
            n = $urandom_range(1, 7);
         end else begin
            kind = 1'b0;
            n = $urandom_range(8, 40);
         end
         for (int i = 0; i < n; i++) q.push_back(8'($urandom));
         // verify datagrams: some well formed, some with a zero or wrong checksum or a bad header
         if (!kind && n >= 8) begin
            hlen = n - $urandom_range(0, (n - 8 < 3) ? n - 8 : 3);
            if (style >= 88) begin
               case ($urandom_range(2))
                  0: hlen = $urandom_range(0, 7);
                  1: hlen = n + $urandom_range(1, 200);
                  default: hlen = $urandom_range(0, 65535);
               endcase
            end
            q[4] = hlen[15:8];
            q[5] = hlen[7:0];
            if (style < 60) csum = udp_checksum(src, dst, q, hlen);
            else if (style < 70) csum = '0;
            else if (style < 88)
               csum = udp_checksum(src, dst, q, hlen) ^ 16'($urandom_range(1, 65535));
            else csum = 16'($urandom);
            q[6] = csum[15:8];
            q[7] = csum[7:0];
         end
         send_datagram(kind, q, src, dst);
         sent += n;
      end
   endtask

   // Result sink with random back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Check each result beat against the oldest prediction
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result expected none actual %h/%b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 16'(want.status), 16'(rsp_tdata[1:0]));
            compare_field("checksum_value", want.checksum_value, rsp_tdata[17:2]);
            compare_field("source_port", want.source_port, rsp_tdata[33:18]);
            compare_field("destination_port", want.destination_port, rsp_tdata[49:34]);
            compare_field("datagram_length", want.datagram_length, rsp_tdata[65:50]);
            compare_field("pad", 16'h0000, 16'(rsp_tdata[71:66]));
            compare_field("generated", 16'(want.generated), 16'(rsp_tuser));
         end
      end
   end

   // Hang detection
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_stall_pct = 80;
      test_directed_cases();
      test_random_traffic(380);

      send_idle_pct = 80;
      recv_stall_pct = 16;
      test_random_traffic(380);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(380);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> udp_datagram_checksum_engine.f
hdl/udc_pkg.sv
hdl/udc_in_stage.sv
hdl/udc_sum_core.sv
hdl/udc_out_stage.sv
hdl/udp_datagram_checksum_engine.sv
hdl/udc_checker.sv
tb/tb.sv
